### src/assert_macros.svh
// Assertion macros shared by the connection table RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define CTE_ASSERT_INV(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("invariant violated");

// A trigger that must be followed by a consequence in the next cycle.
`define CTE_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("sequence violated");

`endif

### src/cte_pkg.sv
// Package for the connection table engine: table size, entry layout,
// command, status and sequencer state codes. Depends on nothing.
`default_nettype none

package cte_pkg;

  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [31:0] FIRST_CLIENT_ID = 32'd1;
  localparam logic [7:0]  ERROR_LIMIT_RST = 8'd3;
  localparam logic [7:0]  COUNT_MAX       = 8'hFF;

  typedef struct packed {
    logic [15:0] handle;
    logic [31:0] conn_id;
    logic [7:0]  errors;
    logic [7:0]  notifications;
  } entry_t;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_LOOKUP = 3'd2,
    CMD_ERROR  = 3'd3,
    CMD_CLEAR  = 3'd4,
    CMD_NOTIFY = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK           = 2'd0,
    STS_NOT_FOUND    = 2'd1,
    STS_FULL         = 2'd2,
    STS_DISCONNECTED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

endpackage

`default_nettype wire

### src/cte_if.sv
// Channel interfaces of the connection table engine: command, response and
// configuration write. Each carries valid, ready and its payload fields.
`default_nettype none

interface cte_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] handle;
  logic [31:0] conn_id;
  logic        force_req;

  modport source (output valid, command, handle, conn_id, force_req, input ready);
  modport sink   (input valid, command, handle, conn_id, force_req, output ready);
endinterface

interface cte_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] handle_out;
  logic [31:0] id_out;
  logic        close_handle;
  logic        drop_subscriptions;

  modport source (output valid, status, handle_out, id_out, close_handle,
                  drop_subscriptions, input ready);
  modport sink   (input valid, status, handle_out, id_out, close_handle,
                  drop_subscriptions, output ready);
endinterface

interface cte_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] error_limit;

  modport source (output valid, error_limit, input ready);
  modport sink   (input valid, error_limit, output ready);
endinterface

`default_nettype wire

### src/connection_table_engine.sv
// Connection table engine: a fixed table of client connections scanned by
// one shared compare unit. Depends on cte_pkg, cte_if.sv and assert_macros.svh.
//
// Commands arrive on cmd_i as valid/ready transactions carrying a command
// code, a connection handle, a client id and a force flag; each one yields
// exactly one response transaction on rsp_o. The user must write the error
// limit on cfg_i, always ready, only while no command is in flight; unchecked.
//
// A command is accepted only while the sequencer is idle. The table is read
// one entry per cycle into a read register and compared there; the scan stops
// at the first match or after the last entry, and the update step then
// registers the response. Unknown commands and error or notification reports
// with handle zero skip the scan. The sequencer is idle again, ready for the
// next command, once the response is registered.
//
// A response waits in an output register while the receiver stalls; one
// more command may be accepted meanwhile and its response is held in the
// update step, with cmd_i not ready, until the register frees up. Reset
// empties the table and sets the next client id to 1 and the error limit to 3.
`default_nettype none

`include "assert_macros.svh"

module connection_table_engine (
  input  wire        clk_i,
  input  wire        rst_ni,
  cte_cfg_if.sink    cfg_i,
  cte_cmd_if.sink    cmd_i,
  cte_rsp_if.source  rsp_o
);

  localparam int unsigned N     = cte_pkg::TABLE_ENTRIES;
  localparam int unsigned IDX_W = cte_pkg::IDX_W;
  localparam int unsigned CNT_W = cte_pkg::CNT_W;

  // Sequencer and command registers.
  cte_pkg::state_e state_q, state_d;
  logic [2:0]      cmd_q;
  logic [15:0]     handle_q;
  logic [31:0]     cid_q;
  logic            force_q;
  logic            hit_q, hit_d;

  // Scan pipeline: the issue counter addresses the memory, and the read
  // data with its index is registered and compared in the following cycle.
  logic [CNT_W-1:0] scan_cnt_q, scan_cnt_d;
  logic             pipe_vld_q, pipe_vld_d;
  logic             rd_en;
  cte_pkg::entry_t  rd_q;
  logic [IDX_W-1:0] rd_idx_q;

  // Table storage. Valid bits are flip-flops so reset empties the table.
  cte_pkg::entry_t  entry_mem [N];
  logic [N-1:0]     valid_q, valid_d;
  logic             mem_we;
  cte_pkg::entry_t  mem_wdata;

  logic [31:0] next_id_q, next_id_d;
  logic [31:0] next_id_inc;
  logic [7:0]  err_limit_q;
  logic [7:0]  err_inc;
  logic        rd_valid;
  logic        match;
  logic        skip_scan;

  // Response register.
  logic        rsp_valid_q, rsp_valid_d;
  logic        rsp_load;
  logic [1:0]  status_q, status_d;
  logic [15:0] handle_out_q, handle_out_d;
  logic [31:0] id_out_q, id_out_d;
  logic        close_q, close_d;
  logic        drop_q, drop_d;

  assign cfg_i.ready = 1'b1;
  assign cmd_i.ready = (state_q == cte_pkg::ST_IDLE);

  assign rsp_o.valid              = rsp_valid_q;
  assign rsp_o.status             = status_q;
  assign rsp_o.handle_out         = handle_out_q;
  assign rsp_o.id_out             = id_out_q;
  assign rsp_o.close_handle       = close_q;
  assign rsp_o.drop_subscriptions = drop_q;

  // Commands that never touch the table go straight to the update step.
  assign skip_scan = (cmd_i.command > cte_pkg::CMD_NOTIFY) ||
                     (((cmd_i.command == cte_pkg::CMD_ERROR) ||
                       (cmd_i.command == cte_pkg::CMD_NOTIFY)) &&
                      (cmd_i.handle == 16'd0));

  assign rd_valid = valid_q[rd_idx_q];

  // Shared compare unit, one entry per cycle: key match or free entry for add.
  always_comb begin
    case (cmd_q)
      cte_pkg::CMD_ADD:    match = !rd_valid;
      cte_pkg::CMD_REMOVE: match = rd_valid && (rd_q.handle == handle_q) &&
                                   (force_q || (rd_q.conn_id == cid_q));
      cte_pkg::CMD_LOOKUP: match = rd_valid && (rd_q.conn_id == cid_q);
      cte_pkg::CMD_ERROR,
      cte_pkg::CMD_CLEAR,
      cte_pkg::CMD_NOTIFY: match = rd_valid && (rd_q.handle == handle_q);
      default:             match = 1'b0;
    endcase
  end

  assign next_id_inc = next_id_q + 32'd1;
  assign err_inc     = (rd_q.errors == cte_pkg::COUNT_MAX) ? rd_q.errors
                                                          : rd_q.errors + 8'd1;

  always_comb begin
    state_d      = state_q;
    scan_cnt_d   = scan_cnt_q;
    pipe_vld_d   = pipe_vld_q;
    hit_d        = hit_q;
    rd_en        = 1'b0;
    mem_we       = 1'b0;
    mem_wdata    = rd_q;
    valid_d      = valid_q;
    next_id_d    = next_id_q;
    rsp_load     = 1'b0;
    status_d     = cte_pkg::STS_OK;
    handle_out_d = 16'd0;
    id_out_d     = 32'd0;
    close_d      = 1'b0;
    drop_d       = 1'b0;

    case (state_q)
      cte_pkg::ST_IDLE: begin
        if (cmd_i.valid) begin
          scan_cnt_d = '0;
          pipe_vld_d = 1'b0;
          hit_d      = 1'b0;
          state_d    = skip_scan ? cte_pkg::ST_UPDATE : cte_pkg::ST_SCAN;
        end
      end

      cte_pkg::ST_SCAN: begin
        if (pipe_vld_q && match) begin
          // Hold the read register: it carries the hit entry into update.
          hit_d   = 1'b1;
          state_d = cte_pkg::ST_UPDATE;
        end else if (pipe_vld_q && (rd_idx_q == IDX_W'(N - 1))) begin
          hit_d   = 1'b0;
          state_d = cte_pkg::ST_UPDATE;
        end else if (scan_cnt_q < CNT_W'(N)) begin
          rd_en      = 1'b1;
          scan_cnt_d = scan_cnt_q + CNT_W'(1);
          pipe_vld_d = 1'b1;
        end
      end

      cte_pkg::ST_UPDATE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = cte_pkg::ST_IDLE;
          case (cmd_q)
            cte_pkg::CMD_ADD: begin
              if (hit_q) begin
                mem_we            = 1'b1;
                mem_wdata         = '{handle: handle_q, conn_id: next_id_q,
                                      errors: 8'd0, notifications: 8'd0};
                valid_d[rd_idx_q] = 1'b1;
                id_out_d          = next_id_q;
                // Ids skip all-ones and zero and restart at one.
                if ((next_id_inc == '1) || (next_id_inc == '0)) begin
                  next_id_d = cte_pkg::FIRST_CLIENT_ID;
                end else begin
                  next_id_d = next_id_inc;
                end
              end else begin
                status_d = cte_pkg::STS_FULL;
              end
            end
            cte_pkg::CMD_REMOVE: begin
              if (hit_q) begin
                valid_d[rd_idx_q] = 1'b0;
                close_d           = 1'b1;
                drop_d            = |rd_q.notifications;
              end else begin
                status_d = cte_pkg::STS_NOT_FOUND;
              end
            end
            cte_pkg::CMD_LOOKUP: begin
              if (hit_q) begin
                handle_out_d = rd_q.handle;
              end else begin
                status_d = cte_pkg::STS_NOT_FOUND;
              end
            end
            cte_pkg::CMD_ERROR: begin
              if (hit_q) begin
                if (err_inc >= err_limit_q) begin
                  valid_d[rd_idx_q] = 1'b0;
                  close_d           = 1'b1;
                  status_d          = cte_pkg::STS_DISCONNECTED;
                end else begin
                  mem_we           = 1'b1;
                  mem_wdata.errors = err_inc;
                end
              end
            end
            cte_pkg::CMD_CLEAR: begin
              if (hit_q) begin
                mem_we           = 1'b1;
                mem_wdata.errors = 8'd0;
              end
            end
            cte_pkg::CMD_NOTIFY: begin
              if (hit_q && (rd_q.notifications != cte_pkg::COUNT_MAX)) begin
                mem_we                  = 1'b1;
                mem_wdata.notifications = rd_q.notifications + 8'd1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      default: state_d = cte_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cte_pkg::ST_IDLE;
      scan_cnt_q  <= '0;
      pipe_vld_q  <= 1'b0;
      hit_q       <= 1'b0;
      valid_q     <= '0;
      next_id_q   <= cte_pkg::FIRST_CLIENT_ID;
      err_limit_q <= cte_pkg::ERROR_LIMIT_RST;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_cnt_q  <= scan_cnt_d;
      pipe_vld_q  <= pipe_vld_d;
      hit_q       <= hit_d;
      valid_q     <= valid_d;
      next_id_q   <= next_id_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_i.valid) begin
        err_limit_q <= cfg_i.error_limit;
      end
    end
  end

  // Command capture and response payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      cmd_q    <= cmd_i.command;
      handle_q <= cmd_i.handle;
      cid_q    <= cmd_i.conn_id;
      force_q  <= cmd_i.force_req;
    end
    if (rsp_load) begin
      status_q     <= status_d;
      handle_out_q <= handle_out_d;
      id_out_q     <= id_out_d;
      close_q      <= close_d;
      drop_q       <= drop_d;
    end
  end

  // Table memory: one registered read port for the scan, one write port.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q     <= entry_mem[scan_cnt_q[IDX_W-1:0]];
      rd_idx_q <= scan_cnt_q[IDX_W-1:0];
    end
    if (mem_we) begin
      entry_mem[rd_idx_q] <= mem_wdata;
    end
  end

  `CTE_ASSERT_INV(a_next_id_legal, (next_id_q != '0) && (next_id_q != '1))
  `CTE_ASSERT_INV(a_scan_bound, scan_cnt_q <= CNT_W'(N))
  `CTE_ASSERT_NEXT(a_accept_busy, cmd_i.valid && cmd_i.ready, state_q != cte_pkg::ST_IDLE)
  `CTE_ASSERT_INV(a_rsp_from_update, !$rose(rsp_valid_q) || $past(state_q == cte_pkg::ST_UPDATE))

endmodule

`default_nettype wire
